[hw/rtl/kpsc_pkg.sv]
// Shared types and constants for the keypad scanner with line buffer.
// Holds scan phases, controller states, command/status structs and the key map.
// No dependencies.
package kpsc_pkg;

    localparam int          SETTLE_W     = 10;
    localparam int          WAIT_W       = 20;
    localparam int          RESULT_LIMIT = 32;
    localparam logic [7:0]  HASH_KEY     = 8'h23;

    localparam logic [SETTLE_W-1:0] SETTLE_RESET   = 10'd10;
    localparam logic [WAIT_W-1:0]   DEBOUNCE_RESET = 20'd150000;
    localparam logic [WAIT_W-1:0]   IDLE_RESET     = 20'd50000;

    localparam logic [1:0] CFG_SETTLE   = 2'd0;
    localparam logic [1:0] CFG_DEBOUNCE = 2'd1;
    localparam logic [1:0] CFG_IDLE     = 2'd2;

    typedef enum logic [1:0] {
        PH_SETTLE,
        PH_DEBOUNCE,
        PH_IDLE
    } phase_t;

    typedef enum logic [1:0] {
        CS_RUN,
        CS_READ,
        CS_WAIT
    } ctrl_state_t;

    typedef struct packed {
        logic tick_take;
        logic rd_issue;
        logic load_char;
    } kpsc_cmd_t;

    typedef struct packed {
        logic hash_emit;
        logic slot_free;
        logic last_char;
    } kpsc_stat_t;

    function automatic logic [7:0] key_map(input logic [1:0] row, input logic [1:0] col);
        logic [7:0] code;
        case ({row, col})
            4'h0: code = 8'h31;
            4'h1: code = 8'h32;
            4'h2: code = 8'h33;
            4'h3: code = 8'h41;
            4'h4: code = 8'h34;
            4'h5: code = 8'h35;
            4'h6: code = 8'h36;
            4'h7: code = 8'h42;
            4'h8: code = 8'h37;
            4'h9: code = 8'h38;
            4'hA: code = 8'h39;
            4'hB: code = 8'h43;
            4'hC: code = 8'h2A;
            4'hD: code = 8'h30;
            4'hE: code = HASH_KEY;
            4'hF: code = 8'h44;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

[hw/rtl/kpsc_ctrl.sv]
// Controller state machine: accepts ticks and sequences the entry readout.
// Depends on kpsc_pkg.
module kpsc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  kpsc_pkg::kpsc_stat_t stat,
    output kpsc_pkg::kpsc_cmd_t  cmd
);
    import kpsc_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_RUN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CS_RUN:
            begin
                if (in_valid && stat.slot_free && stat.hash_emit)
                begin
                    state_next = CS_READ;
                end
            end
            CS_READ:
            begin
                state_next = CS_WAIT;
            end
            CS_WAIT:
            begin
                if (stat.slot_free && stat.last_char)
                begin
                    state_next = CS_RUN;
                end
            end
            default:
            begin
                state_next = CS_RUN;
            end
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        cmd.tick_take = 1'b0;
        cmd.rd_issue  = 1'b0;
        cmd.load_char = 1'b0;
        case (state_reg)
            CS_RUN:
            begin
                in_ready      = stat.slot_free;
                cmd.tick_take = in_valid && stat.slot_free;
            end
            CS_READ:
            begin
                cmd.rd_issue = 1'b1;
            end
            CS_WAIT:
            begin
                cmd.load_char = stat.slot_free;
                cmd.rd_issue  = stat.slot_free && !stat.last_char;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

[hw/rtl/kpsc_datapath.sv]
// Datapath: config registers, row scan timing, entry memory and output register.
// Depends on kpsc_pkg; driven by kpsc_ctrl commands.
module kpsc_datapath #(
    parameter int ENTRY_DEPTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr,
    input  logic [1:0]           cfg_index,
    input  logic [19:0]          cfg_data,
    input  logic [3:0]           col_levels,
    input  kpsc_pkg::kpsc_cmd_t  cmd,
    output kpsc_pkg::kpsc_stat_t stat,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [3:0]           row_drive,
    output logic                 key_valid,
    output logic [7:0]           key_code,
    output logic                 entry_done,
    output logic                 char_valid,
    output logic [7:0]           entry_char,
    output logic                 entry_last
);
    import kpsc_pkg::*;

    localparam int CNT_W  = $clog2(ENTRY_DEPTH + 1);
    localparam int ADDR_W = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1;
    localparam int LIMIT  = (ENTRY_DEPTH < RESULT_LIMIT) ? ENTRY_DEPTH : RESULT_LIMIT;
    localparam logic [CNT_W-1:0] LIMIT_C = CNT_W'(LIMIT);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(ENTRY_DEPTH);

    logic [SETTLE_W-1:0] settle_reg;
    logic [WAIT_W-1:0]   debounce_reg;
    logic [WAIT_W-1:0]   idle_reg;

    phase_t              phase_reg;
    phase_t              phase_next;
    logic [1:0]          row_reg;
    logic [1:0]          row_next;
    logic [WAIT_W-1:0]   wait_reg;
    logic [WAIT_W-1:0]   wait_next;
    logic [3:0]          lines_reg;
    logic [3:0]          lines_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    emit_idx_reg;
    logic [CNT_W-1:0]    emit_n_reg;
    logic [7:0]          rd_data_reg;
    logic [7:0]          entry_mem [ENTRY_DEPTH];

    logic                out_valid_reg;
    logic [3:0]          row_drive_reg;
    logic                key_valid_reg;
    logic [7:0]          key_code_reg;
    logic                entry_done_reg;
    logic                char_valid_reg;
    logic [7:0]          entry_char_reg;
    logic                entry_last_reg;

    logic                hit;
    logic [1:0]          col_sel;
    logic                kv;
    logic [7:0]          kc;
    logic                is_hash;
    logic [CNT_W-1:0]    emit_n;
    logic                store_key;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg   <= SETTLE_RESET;
            debounce_reg <= DEBOUNCE_RESET;
            idle_reg     <= IDLE_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                CFG_SETTLE:   settle_reg   <= cfg_data[SETTLE_W-1:0];
                CFG_DEBOUNCE: debounce_reg <= cfg_data;
                CFG_IDLE:     idle_reg     <= cfg_data;
                default:      settle_reg   <= settle_reg;
            endcase
        end
    end

    always_comb
    begin
        hit = (col_levels != 4'hF);
        if (!col_levels[0])
        begin
            col_sel = 2'd0;
        end
        else if (!col_levels[1])
        begin
            col_sel = 2'd1;
        end
        else if (!col_levels[2])
        begin
            col_sel = 2'd2;
        end
        else
        begin
            col_sel = 2'd3;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        row_next   = row_reg;
        lines_next = lines_reg;
        wait_next  = wait_reg;
        kv         = 1'b0;
        kc         = 8'h00;
        if (wait_reg != '0)
        begin
            wait_next = wait_reg - 1'b1;
        end
        else
        begin
            case (phase_reg)
                PH_DEBOUNCE:
                begin
                    phase_next = PH_IDLE;
                    wait_next  = idle_reg;
                end
                PH_IDLE:
                begin
                    phase_next = PH_SETTLE;
                    row_next   = 2'd0;
                    lines_next = 4'b1110;
                    wait_next  = WAIT_W'(settle_reg);
                end
                default:
                begin
                    if (hit)
                    begin
                        kv         = 1'b1;
                        kc         = key_map(row_reg, col_sel);
                        phase_next = PH_DEBOUNCE;
                        wait_next  = debounce_reg;
                    end
                    else if (row_reg != 2'd3)
                    begin
                        row_next   = row_reg + 2'd1;
                        lines_next = ~(4'b0001 << (row_reg + 2'd1));
                        wait_next  = WAIT_W'(settle_reg);
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        wait_next  = idle_reg;
                    end
                end
            endcase
        end
    end

    assign is_hash   = kv && (kc == HASH_KEY);
    assign emit_n    = (count_reg > LIMIT_C) ? LIMIT_C : count_reg;
    assign store_key = cmd.tick_take && kv && !is_hash && (count_reg < DEPTH_C);

    assign stat.hash_emit = is_hash && (emit_n != '0);
    assign stat.slot_free = !out_valid_reg || out_ready;
    assign stat.last_char = (emit_idx_reg == emit_n_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SETTLE;
            row_reg   <= 2'd0;
            wait_reg  <= WAIT_W'(SETTLE_RESET);
            lines_reg <= 4'b1110;
            count_reg <= '0;
        end
        else if (cmd.tick_take)
        begin
            phase_reg <= phase_next;
            row_reg   <= row_next;
            wait_reg  <= wait_next;
            lines_reg <= lines_next;
            if (is_hash)
            begin
                count_reg <= '0;
            end
            else if (store_key)
            begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_idx_reg <= '0;
            emit_n_reg   <= '0;
        end
        else if (cmd.tick_take && is_hash)
        begin
            emit_idx_reg <= '0;
            emit_n_reg   <= emit_n;
        end
        else if (cmd.rd_issue)
        begin
            emit_idx_reg <= emit_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_key)
        begin
            entry_mem[count_reg[ADDR_W-1:0]] <= kc;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= entry_mem[emit_idx_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((cmd.tick_take && !stat.hash_emit) || cmd.load_char)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tick_take && !stat.hash_emit)
        begin
            row_drive_reg  <= lines_next;
            key_valid_reg  <= kv;
            key_code_reg   <= kc;
            entry_done_reg <= is_hash;
            char_valid_reg <= 1'b0;
            entry_char_reg <= 8'h00;
            entry_last_reg <= 1'b1;
        end
        else if (cmd.load_char)
        begin
            row_drive_reg  <= lines_reg;
            key_valid_reg  <= 1'b1;
            key_code_reg   <= HASH_KEY;
            entry_done_reg <= 1'b1;
            char_valid_reg <= 1'b1;
            entry_char_reg <= rd_data_reg;
            entry_last_reg <= stat.last_char;
        end
    end

    assign out_valid  = out_valid_reg;
    assign row_drive  = row_drive_reg;
    assign key_valid  = key_valid_reg;
    assign key_code   = key_code_reg;
    assign entry_done = entry_done_reg;
    assign char_valid = char_valid_reg;
    assign entry_char = entry_char_reg;
    assign entry_last = entry_last_reg;

endmodule

[hw/rtl/keypad_scanner_with_line_buffer.sv]
// Top level of the 4x4 keypad scanner with key line buffer.
// Instantiates kpsc_ctrl and kpsc_datapath; depends on kpsc_pkg.
//
// Usage:
//   The input stream carries one timer tick per beat with the four column
//   levels. Each tick returns one output beat with the row drive pattern and
//   any key found on that tick. A '#' key closes the entry: every stored key
//   (at most 32) leaves as its own beat, tlast on the final one; an empty
//   entry gives one beat with the char flag clear.
//   An accepted tick's beat is registered straight into the output register;
//   for a '#' with stored keys the first beat passes the READ state and the
//   entry memory read register first. Plain ticks sustain one per cycle while
//   the receiver takes each beat. A '#' with stored keys holds tready low until
//   its last beat is loaded: one memory read to prime, then one beat per cycle,
//   while the receiver takes them, from the registered read port of the memory.
//   The config channel is always ready; write only while the block is idle.
//   Reset loads default timings, points the scan at row 0 and empties the
//   buffer; no clearing pass is needed.
//   When the receiver stalls, the output register holds its beat and the
//   input channel drops tready until the beat is taken.
module keypad_scanner_with_line_buffer #(
    parameter int ENTRY_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [3:0] col_levels, [7:4] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [3:0] row_drive, [11:4] key_code,
                                        // [19:12] entry_char, [23:20] zero
    output logic [2:0]  m_axis_tuser,   // [0] key_valid, [1] entry_done, [2] char_valid
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data
);
    import kpsc_pkg::*;

    kpsc_cmd_t  cmd;
    kpsc_stat_t stat;
    logic [3:0] row_drive;
    logic [7:0] key_code;
    logic [7:0] entry_char;

    assign cfg_ready = 1'b1;

    kpsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    kpsc_datapath #(
        .ENTRY_DEPTH (ENTRY_DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .col_levels (s_axis_tdata[3:0]),
        .cmd        (cmd),
        .stat       (stat),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .row_drive  (row_drive),
        .key_valid  (m_axis_tuser[0]),
        .key_code   (key_code),
        .entry_done (m_axis_tuser[1]),
        .char_valid (m_axis_tuser[2]),
        .entry_char (entry_char),
        .entry_last (m_axis_tlast)
    );

    assign m_axis_tdata = {4'h0, entry_char, key_code, row_drive};

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for keypad_scanner_with_line_buffer: emulated key presses
// and noise ticks go in, every output beat is predicted and compared in order.
// Depends on kpsc_pkg and the keypad_scanner_with_line_buffer RTL.
module tb_top;
    import kpsc_pkg::*;

    localparam int         ENTRY_DEPTH  = 32;
    localparam int         LIMIT_CYCLES = 200000;
    localparam int         HOLD_CYCLES  = 400;
    localparam logic [1:0] CFG_UNUSED   = 2'd3;
    localparam string      KEY_LAYOUT   = "123A456B789C*0#D";

    typedef struct packed {
        logic [3:0] row_drive;
        logic       key_valid;
        logic [7:0] key_code;
        logic       entry_done;
        logic       char_valid;
        logic [7:0] entry_char;
        logic       last;
    } scan_beat_t;

    class scan_tracker;
        logic [9:0]  settle_ticks;
        logic [19:0] debounce_ticks;
        logic [19:0] idle_ticks;
        phase_t      phase;
        logic [1:0]  row_idx;
        logic [19:0] wait_cnt;
        logic [3:0]  row_lines;
        logic [7:0]  key_buf [ENTRY_DEPTH];
        int          key_cnt;
        bit          key_hit;
        int          errors;
        scan_beat_t  pending_beats [$];

        function new();
            settle_ticks   = SETTLE_RESET;
            debounce_ticks = DEBOUNCE_RESET;
            idle_ticks     = IDLE_RESET;
            phase          = PH_SETTLE;
            row_idx        = 2'd0;
            wait_cnt       = 20'(SETTLE_RESET);
            row_lines      = 4'b1110;
            key_cnt        = 0;
            key_hit        = 1'b0;
            errors         = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [19:0] data);
            case (idx)
                CFG_SETTLE:   settle_ticks   = data[9:0];
                CFG_DEBOUNCE: debounce_ticks = data;
                CFG_IDLE:     idle_ticks     = data;
                default:      ;
            endcase
        endfunction

        function void take_tick(logic [3:0] cols);
            scan_beat_t beat;
            logic [7:0] code;
            int         hit_col;
            int         n;
            key_hit = 1'b0;
            code    = 8'h00;
            hit_col = -1;
            if (wait_cnt != 0) begin
                wait_cnt--;
            end
            else begin
                case (phase)
                    PH_DEBOUNCE:
                    begin
                        phase    = PH_IDLE;
                        wait_cnt = idle_ticks;
                    end
                    PH_IDLE:
                    begin
                        phase     = PH_SETTLE;
                        row_idx   = 2'd0;
                        row_lines = 4'b1110;
                        wait_cnt  = 20'(settle_ticks);
                    end
                    default:
                    begin
                        for (int c = 3; c >= 0; c--)
                            if (!cols[c])
                                hit_col = c;
                        if (hit_col >= 0) begin
                            key_hit  = 1'b1;
                            code     = KEY_LAYOUT[4 * row_idx + hit_col];
                            phase    = PH_DEBOUNCE;
                            wait_cnt = debounce_ticks;
                        end
                        else if (row_idx < 2'd3) begin
                            row_idx++;
                            row_lines = ~(4'b0001 << row_idx);
                            wait_cnt  = 20'(settle_ticks);
                        end
                        else begin
                            phase    = PH_IDLE;
                            wait_cnt = idle_ticks;
                        end
                    end
                endcase
            end

            beat = '{row_drive: row_lines, key_valid: key_hit, key_code: code,
                     entry_done: 1'b0, char_valid: 1'b0, entry_char: 8'h00, last: 1'b1};
            if (key_hit && code == HASH_KEY) begin
                n       = (key_cnt > RESULT_LIMIT) ? RESULT_LIMIT : key_cnt;
                key_cnt = 0;
                beat.entry_done = 1'b1;
                if (n == 0)
                    pending_beats.push_back(beat);
                for (int i = 0; i < n; i++) begin
                    beat.char_valid = 1'b1;
                    beat.entry_char = key_buf[i];
                    beat.last       = (i == n - 1);
                    pending_beats.push_back(beat);
                end
            end
            else begin
                if (key_hit && key_cnt < ENTRY_DEPTH) begin
                    key_buf[key_cnt] = code;
                    key_cnt++;
                end
                pending_beats.push_back(beat);
            end
        endfunction

        function void check_beat(scan_beat_t got);
            scan_beat_t want;
            if (pending_beats.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat, expected none, actual %h", $time, got);
                return;
            end
            want = pending_beats.pop_front();
            if (got !== want) begin
                errors++;
                $display({"%0t: beat mismatch expected row=%h kv=%b key=%h done=%b cv=%b ",
                          "char=%h last=%b actual row=%h kv=%b key=%h done=%b cv=%b ",
                          "char=%h last=%b"}, $time,
                         want.row_drive, want.key_valid, want.key_code, want.entry_done,
                         want.char_valid, want.entry_char, want.last,
                         got.row_drive, got.key_valid, got.key_code, got.entry_done,
                         got.char_valid, got.entry_char, got.last);
            end
        endfunction
    endclass

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h0F;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index     = CFG_SETTLE;
    logic [19:0] cfg_data      = 20'h0;

    scan_tracker tracker;
    int          src_idle_pct = 6;
    int          snk_idle_pct = 84;
    int          ticks_sent   = 0;
    int          cycle_cnt    = 0;
    int          hold_left    = 0;
    int          hold_seq     = 0;
    int          hold_seen    = 0;

    keypad_scanner_with_line_buffer #(
        .ENTRY_DEPTH(ENTRY_DEPTH)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_beat('{row_drive: m_axis_tdata[3:0], key_valid: m_axis_tuser[0],
                                 key_code: m_axis_tdata[11:4], entry_done: m_axis_tuser[1],
                                 char_valid: m_axis_tuser[2], entry_char: m_axis_tdata[19:12],
                                 last: m_axis_tlast});
        if (hold_seq != hold_seen) begin
            hold_left = HOLD_CYCLES;
            hold_seen = hold_seq;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else begin
            m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    task automatic set_timing(input logic [19:0] settle, input logic [19:0] debounce,
                              input logic [19:0] idle);
        logic [1:0]  regs [4] = '{CFG_SETTLE, CFG_DEBOUNCE, CFG_IDLE, CFG_UNUSED};
        logic [19:0] vals [4];
        vals = '{settle, debounce, idle, 20'($urandom)};
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            do @(posedge clk); while (!cfg_ready);
            tracker.write_reg(regs[i], vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic send_tick(input logic [3:0] cols);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'h0, cols};
        do @(posedge clk); while (!s_axis_tready);
        tracker.take_tick(cols);
        ticks_sent++;
    endtask

    // hold the key until the scan picks it up
    task automatic press_key(input int row, input logic [3:0] mask);
        do
            send_tick((tracker.row_lines == ~(4'b0001 << row)) ? ~mask : 4'hF);
        while (!tracker.key_hit);
    endtask

    task automatic wait_beats_out();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending_beats.size() != 0)
            @(posedge clk);
    endtask

    task automatic enter_lines(input int tick_goal);
        int         start;
        int         nkeys;
        int         row;
        int         col;
        logic [3:0] mask;
        start = ticks_sent;
        while (ticks_sent - start < tick_goal) begin
            nkeys = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
            repeat (nkeys) begin
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 3))
                        send_tick(4'($urandom_range(0, 15)));
                row = $urandom_range(0, 3);
                col = $urandom_range(0, 3);
                if (row == 3 && col == 2)
                    col = $urandom_range(0, 1);
                mask = (4'b0001 << col) | (4'($urandom_range(0, 15)) << (col + 1));
                press_key(row, mask);
            end
            press_key(3, 4'b0100);
        end
    endtask

    initial
    begin
        tracker = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // drop the upper settle bits: the register keeps only ten
        set_timing(20'hFFC00, 20'd0, 20'd0);
        send_tick(4'h0);
        press_key(3, 4'b0100);
        press_key(0, 4'b0110);
        press_key(3, 4'b1000);
        press_key(2, 4'b1111);
        press_key(3, 4'b0100);
        enter_lines(8);
        wait_beats_out();

        src_idle_pct = 84;
        snk_idle_pct = 6;
        set_timing(20'($urandom_range(0, 3)) | (20'($urandom_range(0, 1023)) << 10),
                   20'($urandom_range(0, 4)), 20'($urandom_range(0, 4)));
        enter_lines(10);
        wait_beats_out();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        set_timing(20'd0, 20'd0, 20'd0);
        hold_seq <= hold_seq + 1;
        repeat (ENTRY_DEPTH + 1)
            press_key(0, 4'($urandom_range(1, 15)));
        press_key(3, 4'b0100);
        wait_beats_out();

        set_timing(20'd2, 20'hFFFFF, 20'd0);
        press_key(1, 4'b0010);
        wait_beats_out();
        set_timing(20'd1023, 20'hFFFFF, 20'hFFFFF);
        repeat (8)
            send_tick(4'($urandom_range(0, 15)));
        wait_beats_out();

        repeat (8) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending_beats.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
